>>> rtl/cpt_pkg.sv
// Shared types, constants and codes of the Clarke/Park transform unit.
// Used by every module of the block and by its assertion checker.
package cpt_pkg;

    localparam int DATA_WIDTH         = 16;
    localparam int ANGLE_WIDTH        = 16;
    localparam int PP_WIDTH           = 7;
    localparam int SINE_WIDTH         = 15;
    localparam int SINE_DEPTH_DEFAULT = 1024;
    localparam int CFG_DATA_WIDTH     = 16;
    localparam int CFG_INDEX_WIDTH    = 2;
    localparam int FRAC_BITS          = 15;
    localparam int ROUND_HALF         = 1 << (FRAC_BITS - 1);
    localparam int INV_SQRT3_Q15      = 18919;
    localparam int ROT_STAGES         = 6;
    localparam int PIPE_STAGES        = PP_WIDTH + ROT_STAGES;

    localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

    // Operation codes; the unused code behaves as Clarke only.
    localparam logic [1:0] FUNC_CLARKE_PARK = 2'd0;
    localparam logic [1:0] FUNC_INV_PARK    = 2'd1;
    localparam logic [1:0] FUNC_CLARKE_ONLY = 2'd2;
    localparam logic [1:0] FUNC_SPARE       = 2'd3;

    // Configuration register indexes; any other index is ignored.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PAIR_COUNT   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ANGLE_OFFSET = 2'd1;

    typedef struct packed {
        logic [1:0]                   func;
        logic signed [DATA_WIDTH-1:0] a_in;
        logic signed [DATA_WIDTH-1:0] b_in;
        logic [ANGLE_WIDTH-1:0]       mech_angle;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x_out;
        logic signed [DATA_WIDTH-1:0] y_out;
        logic [ANGLE_WIDTH-1:0]       elec_angle;
        logic                         saturated;
    } res_word_t;

    // Word handed from one angle cell to the next.
    typedef struct packed {
        logic [1:0]                   func;
        logic signed [DATA_WIDTH-1:0] a;
        logic signed [DATA_WIDTH-1:0] b;
        logic [ANGLE_WIDTH-1:0]       mult;
        logic [PP_WIDTH-1:0]          pp;
        logic [ANGLE_WIDTH-1:0]       acc;
    } cell_word_t;

endpackage

>>> rtl/cpt_angle_cell.sv
// One shift-and-add cell of the electrical angle multiplier chain.
// Depends on cpt_pkg for the cell word type.
module cpt_angle_cell
    import cpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    input  cell_word_t up_word,
    output logic       up_ready,
    output logic       down_valid,
    output cell_word_t down_word,
    input  logic       down_ready
);

    logic       valid_reg;
    cell_word_t word_reg;
    cell_word_t word_next;

    assign up_ready = !valid_reg || down_ready;

    // Add the multiplicand when the low pole pair bit is set, then move to the next bit.
    always_comb
    begin
        word_next      = up_word;
        word_next.acc  = up_word.acc + (up_word.pp[0] ? up_word.mult : '0);
        word_next.mult = up_word.mult << 1;
        word_next.pp   = up_word.pp >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_word  = word_reg;

endmodule

>>> rtl/cpt_sine_rom.sv
// Quarter-wave sine table with two registered read ports.
// Depends on cpt_pkg for the sample width; contents are fixed at elaboration.
module cpt_sine_rom
    import cpt_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT,
    localparam int AW = $clog2(SINE_TABLE_DEPTH + 1)
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [AW-1:0]         addr_a,
    input  logic [AW-1:0]         addr_b,
    output logic [SINE_WIDTH-1:0] data_a,
    output logic [SINE_WIDTH-1:0] data_b
);

    // Entry k is round(32767 * sin(pi/2 * k / depth)) from a Q30 Taylor series.
    function automatic logic [SINE_WIDTH-1:0] sine_entry(input int unsigned k);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        x    = (64'd1686629713 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
        term = x;
        sum  = x;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd110;
        sum  = sum - term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd156;
        sum  = sum + term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd210;
        sum  = sum - term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd272;
        sum  = sum + term;
        v    = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[SINE_WIDTH-1:0];
    endfunction

    logic [SINE_WIDTH-1:0] sine_lut [SINE_TABLE_DEPTH + 1];
    logic [SINE_WIDTH-1:0] data_a_reg;
    logic [SINE_WIDTH-1:0] data_b_reg;

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++)
    begin : g_lut
        assign sine_lut[k] = sine_entry(k);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_a_reg <= sine_lut[addr_a];
            data_b_reg <= sine_lut[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

>>> rtl/cpt_rotator.sv
// Six-stage pipeline: table lookup, Clarke scaling, rotation, rounding, saturation.
// Depends on cpt_pkg and instantiates cpt_sine_rom.
module cpt_rotator
    import cpt_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    input  cell_word_t up_word,
    output logic       up_ready,
    output logic       down_valid,
    output res_word_t  down_word,
    input  logic       down_ready
);

    localparam int AW   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int FW   = ANGLE_WIDTH - 2;
    localparam int PW   = FW + AW;
    localparam int BW   = DATA_WIDTH + 2;
    localparam int SW   = SINE_WIDTH + 1;
    localparam int BPW  = BW + 16;
    localparam int MW   = BW + SW;
    localparam int SUMW = MW + 1;
    localparam int RW   = SUMW - FRAC_BITS;

    localparam logic [AW-1:0]          DEPTH_IDX = AW'(SINE_TABLE_DEPTH);
    localparam logic [PW-1:0]          DEPTH_MUL = PW'(SINE_TABLE_DEPTH);
    localparam logic signed [15:0]     INV_SQRT3 = 16'(INV_SQRT3_Q15);
    localparam logic signed [BPW-1:0]  HALF_B    = BPW'(ROUND_HALF);
    localparam logic signed [SUMW-1:0] HALF_E    = SUMW'(ROUND_HALF);
    localparam logic signed [RW-1:0]   CLIP_HI   = RW'(DATA_MAX);
    localparam logic signed [RW-1:0]   CLIP_LO   = RW'(DATA_MIN);

    logic [ROT_STAGES-1:0] valid_reg;
    logic [ROT_STAGES-1:0] valid_next;
    logic [ROT_STAGES:0]   rdy;

    // Each stage takes a new word when it is empty or its word moves on.
    always_comb
    begin
        rdy[ROT_STAGES] = down_ready;
        for (int i = ROT_STAGES - 1; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i + 1];
        end
        valid_next = rdy[ROT_STAGES-1:0] & {valid_reg[ROT_STAGES-2:0], up_valid}
                   | ~rdy[ROT_STAGES-1:0] & valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign up_ready   = rdy[0];
    assign down_valid = valid_reg[ROT_STAGES-1];

    // Stage A: table indexes, quadrant signs and a + 2b.
    logic [1:0]                   quad;
    logic [PW-1:0]                scaled;
    logic [AW-1:0]                fine_idx;
    logic [AW-1:0]                mirror_idx;
    logic [AW-1:0]                a_sidx_reg;
    logic [AW-1:0]                a_cidx_reg;
    logic                         a_sneg_reg;
    logic                         a_cneg_reg;
    logic [1:0]                   a_func_reg;
    logic signed [DATA_WIDTH-1:0] a_a_reg;
    logic signed [DATA_WIDTH-1:0] a_b_reg;
    logic signed [BW-1:0]         a_ab2_reg;
    logic [ANGLE_WIDTH-1:0]       a_ang_reg;

    assign quad       = up_word.acc[ANGLE_WIDTH-1 -: 2];
    assign scaled     = PW'(up_word.acc[FW-1:0]) * DEPTH_MUL;
    assign fine_idx   = scaled[PW-1:FW];
    assign mirror_idx = DEPTH_IDX - fine_idx;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            a_sidx_reg <= quad[0] ? mirror_idx : fine_idx;
            a_cidx_reg <= quad[0] ? fine_idx : mirror_idx;
            // Clarke then Park uses the negated sine in the shared rotation.
            a_sneg_reg <= quad[1] ^ (up_word.func == FUNC_CLARKE_PARK);
            a_cneg_reg <= quad[1] ^ quad[0];
            a_func_reg <= up_word.func;
            a_a_reg    <= up_word.a;
            a_b_reg    <= up_word.b;
            a_ab2_reg  <= BW'(up_word.a) + (BW'(up_word.b) <<< 1);
            a_ang_reg  <= up_word.acc;
        end
    end

    // Stage B: table read and the 1/sqrt3 product.
    logic [SINE_WIDTH-1:0]        rom_sin;
    logic [SINE_WIDTH-1:0]        rom_cos;
    logic                         b_sneg_reg;
    logic                         b_cneg_reg;
    logic [1:0]                   b_func_reg;
    logic signed [DATA_WIDTH-1:0] b_a_reg;
    logic signed [DATA_WIDTH-1:0] b_b_reg;
    logic signed [BPW-1:0]        b_bprod_reg;
    logic [ANGLE_WIDTH-1:0]       b_ang_reg;

    cpt_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .clk    (clk),
        .en     (rdy[1]),
        .addr_a (a_sidx_reg),
        .addr_b (a_cidx_reg),
        .data_a (rom_sin),
        .data_b (rom_cos)
    );

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            b_sneg_reg  <= a_sneg_reg;
            b_cneg_reg  <= a_cneg_reg;
            b_func_reg  <= a_func_reg;
            b_a_reg     <= a_a_reg;
            b_b_reg     <= a_b_reg;
            b_bprod_reg <= BPW'(a_ab2_reg) * BPW'(INV_SQRT3);
            b_ang_reg   <= a_ang_reg;
        end
    end

    // Stage C: signed sine and cosine, rounded beta, rotation operands.
    logic signed [SW-1:0]         sin_mag;
    logic signed [SW-1:0]         cos_mag;
    logic signed [BPW-1:0]        beta_full;
    logic signed [BW-1:0]         beta;
    logic signed [DATA_WIDTH-1:0] c_p_reg;
    logic signed [BW-1:0]         c_q_reg;
    logic signed [SW-1:0]         c_s_reg;
    logic signed [SW-1:0]         c_c_reg;
    logic [1:0]                   c_func_reg;
    logic [ANGLE_WIDTH-1:0]       c_ang_reg;

    assign sin_mag   = signed'({1'b0, rom_sin});
    assign cos_mag   = signed'({1'b0, rom_cos});
    assign beta_full = (b_bprod_reg + HALF_B) >>> FRAC_BITS;
    assign beta      = beta_full[BW-1:0];

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            c_p_reg    <= b_a_reg;
            c_q_reg    <= (b_func_reg == FUNC_INV_PARK) ? BW'(b_b_reg) : beta;
            c_s_reg    <= b_sneg_reg ? -sin_mag : sin_mag;
            c_c_reg    <= b_cneg_reg ? -cos_mag : cos_mag;
            c_func_reg <= b_func_reg;
            c_ang_reg  <= b_ang_reg;
        end
    end

    // Stage D: the four rotation products.
    logic signed [MW-1:0]         d_pc_reg;
    logic signed [MW-1:0]         d_qs_reg;
    logic signed [MW-1:0]         d_ps_reg;
    logic signed [MW-1:0]         d_qc_reg;
    logic signed [DATA_WIDTH-1:0] d_p_reg;
    logic signed [BW-1:0]         d_q_reg;
    logic [1:0]                   d_func_reg;
    logic [ANGLE_WIDTH-1:0]       d_ang_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            d_pc_reg   <= MW'(c_p_reg) * MW'(c_c_reg);
            d_qs_reg   <= MW'(c_q_reg) * MW'(c_s_reg);
            d_ps_reg   <= MW'(c_p_reg) * MW'(c_s_reg);
            d_qc_reg   <= MW'(c_q_reg) * MW'(c_c_reg);
            d_p_reg    <= c_p_reg;
            d_q_reg    <= c_q_reg;
            d_func_reg <= c_func_reg;
            d_ang_reg  <= c_ang_reg;
        end
    end

    // Stage E: sums, round half up, result selection.
    logic signed [SUMW-1:0] x_sum;
    logic signed [SUMW-1:0] y_sum;
    logic signed [SUMW-1:0] x_rnd;
    logic signed [SUMW-1:0] y_rnd;
    logic signed [RW-1:0]   x_next;
    logic signed [RW-1:0]   y_next;
    logic signed [RW-1:0]   e_x_reg;
    logic signed [RW-1:0]   e_y_reg;
    logic [ANGLE_WIDTH-1:0] e_ang_reg;

    always_comb
    begin
        x_sum = SUMW'(d_pc_reg) - SUMW'(d_qs_reg);
        y_sum = SUMW'(d_ps_reg) + SUMW'(d_qc_reg);
        x_rnd = (x_sum + HALF_E) >>> FRAC_BITS;
        y_rnd = (y_sum + HALF_E) >>> FRAC_BITS;
        case (d_func_reg)
            FUNC_CLARKE_PARK, FUNC_INV_PARK:
            begin
                x_next = x_rnd[RW-1:0];
                y_next = y_rnd[RW-1:0];
            end
            default:
            begin
                // Clarke only, and the unused code with it.
                x_next = RW'(d_p_reg);
                y_next = RW'(d_q_reg);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            e_x_reg   <= x_next;
            e_y_reg   <= y_next;
            e_ang_reg <= d_ang_reg;
        end
    end

    // Stage F: saturation into the output register.
    logic      x_hi;
    logic      x_lo;
    logic      y_hi;
    logic      y_lo;
    res_word_t out_next;
    res_word_t out_reg;

    always_comb
    begin
        x_hi = e_x_reg > CLIP_HI;
        x_lo = e_x_reg < CLIP_LO;
        y_hi = e_y_reg > CLIP_HI;
        y_lo = e_y_reg < CLIP_LO;
        out_next.x_out      = x_hi ? DATA_MAX : (x_lo ? DATA_MIN : e_x_reg[DATA_WIDTH-1:0]);
        out_next.y_out      = y_hi ? DATA_MAX : (y_lo ? DATA_MIN : e_y_reg[DATA_WIDTH-1:0]);
        out_next.elec_angle = e_ang_reg;
        out_next.saturated  = x_hi || x_lo || y_hi || y_lo;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            out_reg <= out_next;
        end
    end

    assign down_word = out_reg;

endmodule

>>> rtl/clarke_park_transform.sv
// Clarke/Park transform unit, top level; uses cpt_pkg, cpt_angle_cell and cpt_rotator.
// The pipeline has 13 register stages: 7 angle cells, then 6 rotator stages.
// Throughput: one word per clock; the pipeline is limited only by result back pressure.
// Reset (rst_n, asynchronous, active low) empties the pipeline and sets the pole pair
// count to 1 and angle_offset to 0. The sine table is constant and needs no initialization.
module clarke_park_transform
    import cpt_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       job_valid,
    output logic                       job_ready,
    input  in_word_t                   job,
    output logic                       res_valid,
    input  logic                       res_ready,
    output res_word_t                  res,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    // Configuration registers. Writes are always taken; an index that names neither
    // register is ignored, and only the low bits that the register holds are kept.
    logic [PP_WIDTH-1:0]    pair_count_reg;
    logic [ANGLE_WIDTH-1:0] angle_offset_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_count_reg   <= PP_WIDTH'(1);
            angle_offset_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PAIR_COUNT:
                begin
                    pair_count_reg <= cfg_data[PP_WIDTH-1:0];
                end
                CFG_ANGLE_OFFSET:
                begin
                    angle_offset_reg <= cfg_data[ANGLE_WIDTH-1:0];
                end
                default:
                begin
                    pair_count_reg <= pair_count_reg;
                end
            endcase
        end
    end

    // The electrical angle is pole pairs * mech_angle - angle_offset, modulo one
    // turn. A row of identical cells forms the product one pole pair bit per cell:
    // each cell adds the shifted mechanical angle when its bit is set, then hands
    // the word on with the multiplicand doubled and the pole pair bits shifted down.
    // The accumulator starts at minus the offset, so the subtraction costs nothing.
    cell_word_t            chain_word  [PP_WIDTH + 1];
    logic [PP_WIDTH:0]     chain_valid;
    logic [PP_WIDTH:0]     chain_ready;

    always_comb
    begin
        chain_word[0].func = job.func;
        chain_word[0].a    = job.a_in;
        chain_word[0].b    = job.b_in;
        chain_word[0].mult = job.mech_angle;
        chain_word[0].pp   = pair_count_reg;
        chain_word[0].acc  = '0 - angle_offset_reg;
    end

    assign chain_valid[0] = job_valid;
    assign job_ready      = chain_ready[0];

    for (genvar i = 0; i < PP_WIDTH; i++)
    begin : g_cell
        cpt_angle_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (chain_valid[i]),
            .up_word    (chain_word[i]),
            .up_ready   (chain_ready[i]),
            .down_valid (chain_valid[i + 1]),
            .down_word  (chain_word[i + 1]),
            .down_ready (chain_ready[i + 1])
        );
    end

    // The rotator looks up sine and cosine, applies Clarke, Park or inverse Park,
    // rounds and saturates. Its stages, like the cells, fill bubbles while the
    // result register waits, so a new word is taken whenever any stage is free.
    cpt_rotator #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rotator (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (chain_valid[PP_WIDTH]),
        .up_word    (chain_word[PP_WIDTH]),
        .up_ready   (chain_ready[PP_WIDTH]),
        .down_valid (res_valid),
        .down_word  (res),
        .down_ready (res_ready)
    );

endmodule

>>> rtl/cpt_checker.sv
// Port-level assertions for the Clarke/Park transform unit, bound to the top level.
// Depends on cpt_pkg for the word types and pipeline depth.
module cpt_checker
    import cpt_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       job_valid,
    input logic                       job_ready,
    input in_word_t                   job,
    input logic                       res_valid,
    input logic                       res_ready,
    input res_word_t                  res,
    input logic                       cfg_valid,
    input logic                       cfg_ready,
    input logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    localparam int CW = $clog2(PIPE_STAGES + 2);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // Words accepted but not yet delivered.
    assign count_next = count_reg + CW'(job_valid && job_ready) - CW'(res_valid && res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result word changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> count_reg != '0)
        else $error("result word without an accepted job");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(PIPE_STAGES))
        else $error("more words in flight than pipeline stages");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !job_ready |-> res_valid && !res_ready)
        else $error("job stalled while the result side is free");

    a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.saturated |-> res.x_out == DATA_MAX || res.x_out == DATA_MIN
            || res.y_out == DATA_MAX || res.y_out == DATA_MIN)
        else $error("saturation flag without a clipped output");

endmodule

bind clarke_park_transform cpt_checker u_cpt_checker (.*);
